>>> sv/mer_pkg.sv
// Shared types, widths and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int COORD_BITS = 10;
	localparam int WALK_W     = COORD_BITS + 1;
	localparam int OUT_W      = COORD_BITS + 2;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int MUL_W      = 2 * COORD_BITS + 4;
	localparam int DEC_W      = 2 * MUL_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

	localparam logic [COORD_BITS-1:0] CENTER_X_RESET = COORD_BITS'(320);
	localparam logic [COORD_BITS-1:0] CENTER_Y_RESET = COORD_BITS'(240);

	localparam logic [3:0] COL_R1_PP = 4'd2;
	localparam logic [3:0] COL_R1_NP = 4'd3;
	localparam logic [3:0] COL_R1_PN = 4'd4;
	localparam logic [3:0] COL_R1_NN = 4'd5;
	localparam logic [3:0] COL_R2_PP = 4'd6;
	localparam logic [3:0] COL_R2_NP = 4'd7;
	localparam logic [3:0] COL_R2_PN = 4'd8;
	localparam logic [3:0] COL_R2_NN = 4'd9;

	localparam logic [1:0] QUAD_LAST = 2'd3;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_RX2_RY,
		MUL_X_RY2,
		MUL_Y_RX2,
		MUL_TX_TX,
		MUL_RY2_P,
		MUL_TY_TY,
		MUL_RX2_P,
		MUL_RX2_RY2
	} mul_op_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CAP_RX2,
		ACT_CAP_RY2,
		ACT_INIT,
		ACT_CAP_A,
		ACT_CAP_B,
		ACT_TRANS,
		ACT_X_INC,
		ACT_Y_DEC,
		ACT_XY_STEP,
		ACT_R1_EVEN,
		ACT_R1_DIAG,
		ACT_R2_VERT,
		ACT_R2_DIAG,
		ACT_FIN
	} act_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_CAPY,
		S_INIT,
		S_CHECK,
		S_TST1,
		S_TST2,
		S_T1,
		S_T2,
		S_T3,
		S_T4,
		S_T5,
		S_R1,
		S_R1M,
		S_R1A,
		S_R1B,
		S_R1C,
		S_R2,
		S_R2M,
		S_R2A,
		S_R2N,
		S_R2P,
		S_R2Q,
		S_EMIT
	} state_t;

	typedef struct packed {
		mul_op_t    mul_op;
		act_t       act;
		logic [1:0] quad;
	} mer_cmd_t;

	typedef struct packed {
		logic fin;
		logic region2;
		logic dec_neg;
		logic dec_pos;
		logic r1_holds;
	} mer_sts_t;

	typedef struct packed {
		logic       neg_x;
		logic       neg_y;
		logic [3:0] colour;
	} quad_info_t;

	// Mirror signs and palette code of one output pixel of a step.
	function automatic quad_info_t quad_info(input logic region2, input logic [1:0] quad);
		quad_info_t q;
		unique case ({region2, quad})
			3'b000:  q = '{neg_x: 1'b0, neg_y: 1'b0, colour: COL_R1_PP};
			3'b001:  q = '{neg_x: 1'b1, neg_y: 1'b0, colour: COL_R1_NP};
			3'b010:  q = '{neg_x: 1'b0, neg_y: 1'b1, colour: COL_R1_PN};
			3'b011:  q = '{neg_x: 1'b1, neg_y: 1'b1, colour: COL_R1_NN};
			3'b100:  q = '{neg_x: 1'b0, neg_y: 1'b0, colour: COL_R2_PP};
			3'b101:  q = '{neg_x: 1'b1, neg_y: 1'b1, colour: COL_R2_NN};
			3'b110:  q = '{neg_x: 1'b1, neg_y: 1'b0, colour: COL_R2_NP};
			default: q = '{neg_x: 1'b0, neg_y: 1'b1, colour: COL_R2_PN};
		endcase
		return q;
	endfunction

endpackage

>>> sv/mer_if.sv
// Handshake channels of the rasterizer: step ticks in, pixels out.
interface mer_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mer_pixel_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mer_pkg::OUT_W-1:0]       pixel_x;
	logic signed [mer_pkg::OUT_W-1:0]       pixel_y;
	logic [3:0]                             colour;
	logic                                   last;
	logic                                   done_res;

	modport source (output valid, output pixel_x, output pixel_y, output colour,
		output last, output done_res, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input colour,
		input last, input done_res, output ready);
endinterface

>>> sv/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
// Usage:
//   Write radius_x, radius_y, center_x, center_y on the cfg port (cfg_we, cfg_idx,
//   cfg_data) while the block is idle. Each transaction on the tick channel advances
//   the ellipse walk by one step; restart=1 reloads the walk from the registers first.
//   A step produces four transactions on the pixel channel (quadrant mirrors with
//   palette codes); last marks the fourth, done_res marks the step that ends the walk.
//   After the walk ends, ticks without restart produce nothing.
// Timing:
//   One step is sequenced through a single shared multiplier with a registered
//   product: arithmetic states run after the tick is taken (restart adds S_INIT,
//   the change from region 1 to 2 adds S_T1 to S_T5), then the four pixels go out.
//   tick.ready is high only between steps. A tick that emits nothing goes back
//   to idle without a pixel transaction. Every step opens by squaring the radii
//   again from the live registers (S_SQX, S_SQY, S_CAPY).
// Reset:
//   Registers take radius 0/0 and center 320/240; the walk is marked finished.
// Stalls:
//   A stalled pixel channel holds the current pixel and no new tick is taken.
module midpoint_ellipse_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	mer_tick_if.sink                        tick,
	mer_pixel_if.source                     pixel,
	input  logic                            cfg_we,
	input  logic [mer_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mer_pkg::COORD_BITS-1:0]  cfg_data
);

	mer_pkg::mer_cmd_t cmd;
	mer_pkg::mer_sts_t sts;

	mer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (tick.valid),
		.in_restart (tick.restart),
		.in_ready   (tick.ready),
		.out_valid  (pixel.valid),
		.out_ready  (pixel.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	mer_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.pixel_x  (pixel.pixel_x),
		.pixel_y  (pixel.pixel_y),
		.colour   (pixel.colour),
		.last     (pixel.last),
		.done_res (pixel.done_res)
	);

endmodule

>>> sv/mer_dp.sv
// Datapath: configuration, walk state, shared multiplier and pixel mirroring.
module mer_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mer_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [mer_pkg::COORD_BITS-1:0]         cfg_data,
	input  mer_pkg::mer_cmd_t                      cmd,
	output mer_pkg::mer_sts_t                      sts,
	output logic signed [mer_pkg::OUT_W-1:0]       pixel_x,
	output logic signed [mer_pkg::OUT_W-1:0]       pixel_y,
	output logic [3:0]                             colour,
	output logic                                   last,
	output logic                                   done_res
);

	logic [mer_pkg::COORD_BITS-1:0] radius_x_q, radius_y_q, center_x_q, center_y_q;
	logic [mer_pkg::WALK_W-1:0]     walk_x_q, walk_y_q;
	logic [mer_pkg::DEC_W-1:0]      decision_q;
	logic                           region2_q;
	logic                           fin_q;
	logic [mer_pkg::SQ_W-1:0]       rx2_q, ry2_q;
	logic [mer_pkg::DEC_W-1:0]      prod_q, a_q, b_q;

	logic [mer_pkg::MUL_W-1:0]      mul_a, mul_b;
	logic [mer_pkg::OUT_W-1:0]      tx;
	logic [mer_pkg::WALK_W-1:0]     ty;
	logic [mer_pkg::DEC_W-1:0]      rx2_e, ry2_e, dec_next;
	logic [mer_pkg::OUT_W-1:0]      cx_e, cy_e, x_e, y_e;
	mer_pkg::quad_info_t            qi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x_q <= '0;
			radius_y_q <= '0;
			center_x_q <= mer_pkg::CENTER_X_RESET;
			center_y_q <= mer_pkg::CENTER_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mer_pkg::REG_RADIUS_X: radius_x_q <= cfg_data;
				mer_pkg::REG_RADIUS_Y: radius_y_q <= cfg_data;
				mer_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				mer_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
			endcase
		end
	end

	assign tx    = {walk_x_q, 1'b1};
	assign ty    = walk_y_q - 1'b1;
	assign rx2_e = mer_pkg::DEC_W'(rx2_q);
	assign ry2_e = mer_pkg::DEC_W'(ry2_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			mer_pkg::MUL_RX_RX: begin
				mul_a = mer_pkg::MUL_W'(radius_x_q);
				mul_b = mer_pkg::MUL_W'(radius_x_q);
			end
			mer_pkg::MUL_RY_RY: begin
				mul_a = mer_pkg::MUL_W'(radius_y_q);
				mul_b = mer_pkg::MUL_W'(radius_y_q);
			end
			mer_pkg::MUL_RX2_RY: begin
				mul_a = mer_pkg::MUL_W'(rx2_q);
				mul_b = mer_pkg::MUL_W'(radius_y_q);
			end
			mer_pkg::MUL_X_RY2: begin
				mul_a = mer_pkg::MUL_W'(walk_x_q);
				mul_b = mer_pkg::MUL_W'(ry2_q);
			end
			mer_pkg::MUL_Y_RX2: begin
				mul_a = mer_pkg::MUL_W'(walk_y_q);
				mul_b = mer_pkg::MUL_W'(rx2_q);
			end
			mer_pkg::MUL_TX_TX: begin
				mul_a = mer_pkg::MUL_W'(tx);
				mul_b = mer_pkg::MUL_W'(tx);
			end
			mer_pkg::MUL_RY2_P: begin
				mul_a = mer_pkg::MUL_W'(ry2_q);
				mul_b = prod_q[mer_pkg::MUL_W-1:0];
			end
			mer_pkg::MUL_TY_TY: begin
				mul_a = mer_pkg::MUL_W'(ty);
				mul_b = mer_pkg::MUL_W'(ty);
			end
			mer_pkg::MUL_RX2_P: begin
				mul_a = mer_pkg::MUL_W'(rx2_q);
				mul_b = prod_q[mer_pkg::MUL_W-1:0];
			end
			mer_pkg::MUL_RX2_RY2: begin
				mul_a = mer_pkg::MUL_W'(rx2_q);
				mul_b = mer_pkg::MUL_W'(ry2_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_op != mer_pkg::MUL_NONE)
			prod_q <= mul_a * mul_b;
		if (cmd.act == mer_pkg::ACT_CAP_RX2)
			rx2_q <= prod_q[mer_pkg::SQ_W-1:0];
		if (cmd.act == mer_pkg::ACT_CAP_RY2)
			ry2_q <= prod_q[mer_pkg::SQ_W-1:0];
		if (cmd.act == mer_pkg::ACT_CAP_A)
			a_q <= prod_q;
		if (cmd.act == mer_pkg::ACT_CAP_B)
			b_q <= prod_q;
	end

	// decision arithmetic is modulo 2^DEC_W, sign in the top bit
	always_comb begin
		dec_next = decision_q;
		case (cmd.act)
			mer_pkg::ACT_INIT:    dec_next = (ry2_e << 2) - (prod_q << 2) + rx2_e;
			mer_pkg::ACT_TRANS:   dec_next = a_q + (b_q << 2) - (prod_q << 2);
			mer_pkg::ACT_R1_EVEN: dec_next = decision_q + (((prod_q << 1) + ry2_e) << 2);
			mer_pkg::ACT_R1_DIAG:
				dec_next = decision_q + (((a_q << 1) - (prod_q << 1) + ry2_e) << 2);
			mer_pkg::ACT_R2_VERT: dec_next = decision_q + ((rx2_e - (prod_q << 1)) << 2);
			mer_pkg::ACT_R2_DIAG:
				dec_next = decision_q + (((a_q << 1) - (prod_q << 1) + rx2_e) << 2);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			decision_q <= '0;
			region2_q  <= 1'b0;
			fin_q      <= 1'b1;
		end else begin
			decision_q <= dec_next;
			case (cmd.act)
				mer_pkg::ACT_INIT: begin
					walk_x_q  <= '0;
					walk_y_q  <= mer_pkg::WALK_W'(radius_y_q);
					region2_q <= 1'b0;
					fin_q     <= (radius_y_q == '0);
				end
				mer_pkg::ACT_TRANS:   region2_q <= 1'b1;
				mer_pkg::ACT_X_INC:   walk_x_q  <= walk_x_q + 1'b1;
				mer_pkg::ACT_Y_DEC:   walk_y_q  <= walk_y_q - 1'b1;
				mer_pkg::ACT_XY_STEP: begin
					walk_x_q <= walk_x_q + 1'b1;
					walk_y_q <= walk_y_q - 1'b1;
				end
				mer_pkg::ACT_FIN:     fin_q <= (walk_y_q == '0);
				default: ;
			endcase
		end
	end

	assign sts.fin      = fin_q;
	assign sts.region2  = region2_q;
	assign sts.dec_neg  = decision_q[mer_pkg::DEC_W-1];
	assign sts.dec_pos  = !decision_q[mer_pkg::DEC_W-1] && (decision_q != '0);
	// region 1 continues while x*ry^2 <= y*rx^2
	assign sts.r1_holds = (a_q <= prod_q);

	assign qi   = mer_pkg::quad_info(region2_q, cmd.quad);
	assign cx_e = mer_pkg::OUT_W'(center_x_q);
	assign cy_e = mer_pkg::OUT_W'(center_y_q);
	assign x_e  = mer_pkg::OUT_W'(walk_x_q);
	assign y_e  = mer_pkg::OUT_W'(walk_y_q);

	assign pixel_x  = qi.neg_x ? cx_e - x_e : cx_e + x_e;
	assign pixel_y  = qi.neg_y ? cy_e - y_e : cy_e + y_e;
	assign colour   = qi.colour;
	assign last     = (cmd.quad == mer_pkg::QUAD_LAST);
	assign done_res = (walk_y_q == '0);

endmodule

>>> sv/mer_ctrl.sv
// Controller: runs one walk step on the datapath; a live walk emits four pixels.
module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_restart,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mer_pkg::mer_cmd_t cmd,
	input  mer_pkg::mer_sts_t sts
);

	mer_pkg::state_t state_q, state_d;
	logic            restart_q;
	logic [1:0]      quad_q;
	logic            out_hs;

	assign out_hs = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mer_pkg::S_IDLE;
			restart_q <= 1'b0;
			quad_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready)
				restart_q <= in_restart;
			if (out_hs)
				quad_q <= quad_q + 1'b1;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.mul_op  = mer_pkg::MUL_NONE;
		cmd.act     = mer_pkg::ACT_NONE;
		cmd.quad    = quad_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			mer_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = mer_pkg::S_SQX;
			end
			mer_pkg::S_SQX: begin
				cmd.mul_op = mer_pkg::MUL_RX_RX;
				state_d    = mer_pkg::S_SQY;
			end
			mer_pkg::S_SQY: begin
				cmd.mul_op = mer_pkg::MUL_RY_RY;
				cmd.act    = mer_pkg::ACT_CAP_RX2;
				state_d    = mer_pkg::S_CAPY;
			end
			mer_pkg::S_CAPY: begin
				cmd.act = mer_pkg::ACT_CAP_RY2;
				if (restart_q) begin
					cmd.mul_op = mer_pkg::MUL_RX2_RY;
					state_d    = mer_pkg::S_INIT;
				end else begin
					state_d = mer_pkg::S_CHECK;
				end
			end
			mer_pkg::S_INIT: begin
				cmd.act = mer_pkg::ACT_INIT;
				state_d = mer_pkg::S_CHECK;
			end
			mer_pkg::S_CHECK: begin
				if (sts.fin)
					state_d = mer_pkg::S_IDLE;
				else if (sts.region2)
					state_d = mer_pkg::S_R2;
				else begin
					cmd.mul_op = mer_pkg::MUL_X_RY2;
					state_d    = mer_pkg::S_TST1;
				end
			end
			mer_pkg::S_TST1: begin
				cmd.mul_op = mer_pkg::MUL_Y_RX2;
				cmd.act    = mer_pkg::ACT_CAP_A;
				state_d    = mer_pkg::S_TST2;
			end
			mer_pkg::S_TST2: begin
				if (sts.r1_holds)
					state_d = mer_pkg::S_R1;
				else begin
					cmd.mul_op = mer_pkg::MUL_TX_TX;
					state_d    = mer_pkg::S_T1;
				end
			end
			// region 2 entry: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
			mer_pkg::S_T1: begin
				cmd.mul_op = mer_pkg::MUL_RY2_P;
				state_d    = mer_pkg::S_T2;
			end
			mer_pkg::S_T2: begin
				cmd.mul_op = mer_pkg::MUL_TY_TY;
				cmd.act    = mer_pkg::ACT_CAP_A;
				state_d    = mer_pkg::S_T3;
			end
			mer_pkg::S_T3: begin
				cmd.mul_op = mer_pkg::MUL_RX2_P;
				state_d    = mer_pkg::S_T4;
			end
			mer_pkg::S_T4: begin
				cmd.mul_op = mer_pkg::MUL_RX2_RY2;
				cmd.act    = mer_pkg::ACT_CAP_B;
				state_d    = mer_pkg::S_T5;
			end
			mer_pkg::S_T5: begin
				cmd.act = mer_pkg::ACT_TRANS;
				state_d = mer_pkg::S_R2;
			end
			mer_pkg::S_R1: begin
				cmd.act = mer_pkg::ACT_X_INC;
				state_d = mer_pkg::S_R1M;
			end
			mer_pkg::S_R1M: begin
				cmd.mul_op = mer_pkg::MUL_X_RY2;
				if (sts.dec_neg)
					state_d = mer_pkg::S_R1A;
				else begin
					cmd.act = mer_pkg::ACT_Y_DEC;
					state_d = mer_pkg::S_R1B;
				end
			end
			mer_pkg::S_R1A: begin
				cmd.act = mer_pkg::ACT_R1_EVEN;
				state_d = mer_pkg::S_EMIT;
			end
			mer_pkg::S_R1B: begin
				cmd.mul_op = mer_pkg::MUL_Y_RX2;
				cmd.act    = mer_pkg::ACT_CAP_A;
				state_d    = mer_pkg::S_R1C;
			end
			mer_pkg::S_R1C: begin
				cmd.act = mer_pkg::ACT_R1_DIAG;
				state_d = mer_pkg::S_EMIT;
			end
			mer_pkg::S_R2: begin
				if (sts.dec_pos) begin
					cmd.act = mer_pkg::ACT_Y_DEC;
					state_d = mer_pkg::S_R2M;
				end else begin
					cmd.act = mer_pkg::ACT_XY_STEP;
					state_d = mer_pkg::S_R2N;
				end
			end
			mer_pkg::S_R2M: begin
				cmd.mul_op = mer_pkg::MUL_Y_RX2;
				state_d    = mer_pkg::S_R2A;
			end
			mer_pkg::S_R2A: begin
				cmd.act = mer_pkg::ACT_R2_VERT;
				state_d = mer_pkg::S_EMIT;
			end
			mer_pkg::S_R2N: begin
				cmd.mul_op = mer_pkg::MUL_X_RY2;
				state_d    = mer_pkg::S_R2P;
			end
			mer_pkg::S_R2P: begin
				cmd.mul_op = mer_pkg::MUL_Y_RX2;
				cmd.act    = mer_pkg::ACT_CAP_A;
				state_d    = mer_pkg::S_R2Q;
			end
			mer_pkg::S_R2Q: begin
				cmd.act = mer_pkg::ACT_R2_DIAG;
				state_d = mer_pkg::S_EMIT;
			end
			mer_pkg::S_EMIT: begin
				// walk_y is stable here, so the done flag can be latched every cycle
				cmd.act   = mer_pkg::ACT_FIN;
				out_valid = 1'b1;
				if (out_ready && (quad_q == mer_pkg::QUAD_LAST))
					state_d = mer_pkg::S_IDLE;
			end
			default: state_d = mer_pkg::S_IDLE;
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("tick accepted while pixels pending");

	a_quad_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (quad_q == '0))
		else $error("pixel counter not back to zero between steps");

	a_last_ends_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && (quad_q == mer_pkg::QUAD_LAST)) |=> in_ready)
		else $error("step did not end after fourth pixel");

	a_stall_holds_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(quad_q)))
		else $error("pixel index moved while stalled");

endmodule

>>> tb/sv/midpoint_ellipse_rasterizer_tb.sv
// Testbench for the midpoint ellipse rasterizer: directed table, random walks, pixel scoreboard.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;
	import mer_pkg::*;

	localparam longint WALK_MASK = (longint'(1) << WALK_W) - 1;
	localparam int     TICKS_TOTAL = 330;
	localparam int     QUIET_FROM = 270;
	localparam int     SETTLE_CYCLES = 30;
	localparam int     MAX_REPORTS = 200;

	typedef struct packed {
		logic [OUT_W-1:0] px;
		logic [OUT_W-1:0] py;
		logic [3:0]       colour;
		logic             last;
		logic             done;
	} pix_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic                 restart;
		logic [CFG_IDX_W-1:0] idx;
		logic [COORD_BITS-1:0] data;
		bit                   typed;
		bit                   none;
		pix_t                 first;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [COORD_BITS-1:0] cfg_data;

	mer_tick_if  tick_ch();
	mer_pixel_if pix_ch();

	midpoint_ellipse_rasterizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.pixel    (pix_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// register shadow
	logic [COORD_BITS-1:0] sh_rx, sh_ry, sh_cx, sh_cy;
	// walk state of the predictor
	longint ex_x, ex_y, ex_d;
	bit     ex_r2, ex_idle;

	pix_t      step_pix[$];
	pix_t      exp_pixels[$];
	stim_row_t plan[$];
	int        err_cnt;
	int        n_ticks;
	bit        idle_on, stall_on;

	always #1 clk = ~clk;

	function automatic void emit_pixel(input bit neg_x, input bit neg_y,
			input logic [3:0] colour, input bit done);
		pix_t p;
		p.px = neg_x ? OUT_W'(sh_cx) - OUT_W'(ex_x) : OUT_W'(sh_cx) + OUT_W'(ex_x);
		p.py = neg_y ? OUT_W'(sh_cy) - OUT_W'(ex_y) : OUT_W'(sh_cy) + OUT_W'(ex_y);
		p.colour = colour;
		p.last = (step_pix.size() == 3);
		p.done = done;
		step_pix.push_back(p);
	endfunction

	// One step of the midpoint walk; the pixels of the step land in step_pix.
	function automatic void advance_walk(input logic rs);
		longint rx2, ry2, tx, ty;
		bit done;
		rx2 = longint'(sh_rx) * longint'(sh_rx);
		ry2 = longint'(sh_ry) * longint'(sh_ry);
		step_pix.delete();
		if (rs) begin
			ex_x = 0;
			ex_y = longint'(sh_ry);
			ex_r2 = 1'b0;
			ex_d = 4 * ry2 - 4 * rx2 * ex_y + rx2;
			ex_idle = (ex_y == 0);
		end
		if (ex_idle)
			return;
		if (!ex_r2 && !(ex_x * ry2 <= ex_y * rx2)) begin
			tx = 2 * ex_x + 1;
			ty = ex_y - 1;
			ex_r2 = 1'b1;
			ex_d = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
		end
		if (!ex_r2) begin
			ex_x = (ex_x + 1) & WALK_MASK;
			if (ex_d < 0) begin
				ex_d += 4 * (2 * ex_x * ry2 + ry2);
			end else begin
				ex_y -= 1;
				ex_d += 4 * (2 * ex_x * ry2 - 2 * ex_y * rx2 + ry2);
			end
		end else if (ex_d > 0) begin
			ex_y -= 1;
			ex_d += 4 * (rx2 - 2 * rx2 * ex_y);
		end else begin
			ex_x = (ex_x + 1) & WALK_MASK;
			ex_y -= 1;
			ex_d += 4 * (2 * ex_x * ry2 - 2 * ex_y * rx2 + rx2);
		end
		done = (ex_y == 0);
		ex_idle = done;
		if (!ex_r2) begin
			emit_pixel(1'b0, 1'b0, COL_R1_PP, done);
			emit_pixel(1'b1, 1'b0, COL_R1_NP, done);
			emit_pixel(1'b0, 1'b1, COL_R1_PN, done);
			emit_pixel(1'b1, 1'b1, COL_R1_NN, done);
		end else begin
			emit_pixel(1'b0, 1'b0, COL_R2_PP, done);
			emit_pixel(1'b1, 1'b1, COL_R2_NN, done);
			emit_pixel(1'b1, 1'b0, COL_R2_NP, done);
			emit_pixel(1'b0, 1'b1, COL_R2_PN, done);
		end
	endfunction

	function automatic void plan_tick(input logic rs, input bit typed, input bit none,
			input pix_t first);
		stim_row_t r;
		r.kind = ROW_TICK;
		r.restart = rs;
		r.idx = REG_RADIUS_X;
		r.data = '0;
		r.typed = typed;
		r.none = none;
		r.first = first;
		plan.push_back(r);
	endfunction

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [COORD_BITS-1:0] data);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.restart = 1'b0;
		r.idx = idx;
		r.data = data;
		r.typed = 1'b0;
		r.none = 1'b0;
		r.first = '0;
		plan.push_back(r);
	endfunction

	// Sends one tick; on acceptance the step is predicted (or typed in) and queued.
	task automatic send_tick(input logic rs, input bit typed = 1'b0, input bit none = 1'b0,
			input pix_t first = '0);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.restart <= rs;
		do @(posedge clk); while (!tick_ch.ready);
		n_ticks++;
		advance_walk(rs);
		if (typed) begin
			if (none)
				step_pix.delete();
			else if (step_pix.size() != 0)
				step_pix[0] = first;
		end
		foreach (step_pix[k])
			exp_pixels.push_back(step_pix[k]);
	endtask

	// Block goes idle: all pixels back, then room for a step that emits nothing.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (exp_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [COORD_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_RADIUS_X: sh_rx = data;
			REG_RADIUS_Y: sh_ry = data;
			REG_CENTER_X: sh_cx = data;
			default:      sh_cy = data;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] pick_radius();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return COORD_BITS'($urandom_range(0, 1023));
			default: return COORD_BITS'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_center();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return COORD_BITS'($urandom_range(0, 1023));
		endcase
	endfunction

	// pixel scoreboard
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (exp_pixels.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t unexpected pixel transaction: x=%0d y=%0d colour=%0d",
						$time, pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.colour);
			end else begin
				pix_t e;
				e = exp_pixels.pop_front();
				if (pix_ch.pixel_x !== e.px || pix_ch.pixel_y !== e.py ||
						pix_ch.colour !== e.colour || pix_ch.last !== e.last ||
						pix_ch.done_res !== e.done) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t pixel mismatch: expected x=%0d y=%0d c=%0d last=%0b done=%0b, actual x=%0d y=%0d c=%0d last=%0b done=%0b",
							$time, $signed(e.px), $signed(e.py), e.colour, e.last, e.done,
							pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.colour, pix_ch.last,
							pix_ch.done_res);
				end
			end
		end
	end

	// pixel sink backpressure
	initial begin
		pix_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_on && $urandom_range(0, 3) == 0) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int steps;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_RADIUS_X;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.restart = 1'b0;
		err_cnt = 0;
		n_ticks = 0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		sh_rx = '0;
		sh_ry = '0;
		sh_cx = CENTER_X_RESET;
		sh_cy = CENTER_Y_RESET;
		ex_x = 0;
		ex_y = 0;
		ex_d = 0;
		ex_r2 = 1'b0;
		ex_idle = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset, then an empty walk with a zero vertical radius
		plan_tick(1'b0, 1'b1, 1'b1, '0);
		plan_tick(1'b1, 1'b1, 1'b1, '0);
		plan_cfg(REG_RADIUS_X, '0);
		plan_cfg(REG_RADIUS_Y, COORD_BITS'(1));
		plan_tick(1'b1, 1'b1, 1'b0, '{OUT_W'(321), OUT_W'(240), COL_R1_PP, 1'b0, 1'b1});
		plan_tick(1'b0, 1'b1, 1'b1, '0);
		// largest radii and centers
		plan_cfg(REG_RADIUS_X, '1);
		plan_cfg(REG_RADIUS_Y, '1);
		plan_cfg(REG_CENTER_X, '1);
		plan_cfg(REG_CENTER_Y, '1);
		plan_tick(1'b1, 1'b1, 1'b0, '{OUT_W'(1024), OUT_W'(2046), COL_R1_PP, 1'b0, 1'b0});
		plan_tick(1'b0, 1'b0, 1'b0, '0);
		// centers moved mid-walk: negative coordinates
		plan_cfg(REG_CENTER_X, '0);
		plan_cfg(REG_CENTER_Y, '0);
		plan_tick(1'b0, 1'b0, 1'b0, '0);
		plan_cfg(REG_RADIUS_Y, '0);
		plan_tick(1'b0, 1'b0, 1'b0, '0);
		// restart abandons the walk; small ellipse through both regions and past done
		plan_cfg(REG_RADIUS_X, COORD_BITS'(4));
		plan_cfg(REG_RADIUS_Y, COORD_BITS'(3));
		plan_cfg(REG_CENTER_X, COORD_BITS'(320));
		plan_cfg(REG_CENTER_Y, COORD_BITS'(240));
		plan_tick(1'b1, 1'b0, 1'b0, '0);
		repeat (10) plan_tick(1'b0, 1'b0, 1'b0, '0);
		// zero horizontal radius
		plan_cfg(REG_RADIUS_X, '0);
		plan_cfg(REG_RADIUS_Y, COORD_BITS'(5));
		plan_tick(1'b1, 1'b0, 1'b0, '0);
		repeat (5) plan_tick(1'b0, 1'b0, 1'b0, '0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i-1].kind == ROW_TICK)
					settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_tick(plan[i].restart, plan[i].typed, plan[i].none, plan[i].first);
			end
		end

		// random walks, each reloaded from fresh registers
		while (n_ticks < TICKS_TOTAL) begin
			idle_on = (n_ticks < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			stall_on = (n_ticks < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			settle();
			write_reg(REG_RADIUS_X, pick_radius());
			write_reg(REG_RADIUS_Y, pick_radius());
			if ($urandom_range(0, 1))
				write_reg(REG_CENTER_X, pick_center());
			if ($urandom_range(0, 1))
				write_reg(REG_CENTER_Y, pick_center());
			send_tick(1'b1);
			steps = 0;
			while (!ex_idle && steps < 40) begin
				send_tick($urandom_range(0, 29) == 0);
				steps++;
				if ($urandom_range(0, 39) == 0) begin
					settle();
					case ($urandom_range(0, 3))
						0:       write_reg(REG_RADIUS_X, pick_radius());
						1:       write_reg(REG_RADIUS_Y, pick_radius());
						2:       write_reg(REG_CENTER_X, pick_center());
						default: write_reg(REG_CENTER_Y, pick_center());
					endcase
				end
			end
			repeat ($urandom_range(0, 2)) send_tick(1'b0);
		end

		tick_ch.valid <= 1'b0;
		while (exp_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> midpoint_ellipse_rasterizer.f
sv/mer_pkg.sv
sv/mer_if.sv
sv/mer_dp.sv
sv/mer_ctrl.sv
sv/midpoint_ellipse_rasterizer.sv
tb/sv/midpoint_ellipse_rasterizer_tb.sv
